### hw/rtl/u8gim_pkg.sv
// ----------------------------------------------------------------------------
// u8gim_pkg: shared types and constants of the UTF-8 glyph index mapper
// Queue entry layout, CSR map, lookup sequencer states.
// ----------------------------------------------------------------------------
package u8gim_pkg;

   localparam logic [15:0] QMARK = 16'h003F;

   // CSR map: byte address bit 2 selects the register word
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_RANGE_COUNT = 1'b0;

   // Queue between decoder and lookup engine
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   // For OP_LOOKUP the code point travels in low
   typedef struct packed {
      op_type      op;
      logic [5:0]  slot;
      logic [15:0] low;
      logic [15:0] high;
   } entry_type;

   typedef struct packed {
      logic       clear;
      logic [6:0] count;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_WALK,
      ST_EMIT
   } back_state_type;

endpackage

### hw/rtl/u8gim_front.sv
// ----------------------------------------------------------------------------
// u8gim_front: UTF-8 decoder
// Accepts requests, assembles code points and pushes load/lookup entries.
// ----------------------------------------------------------------------------
module u8gim_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [5:0]            req_range_slot,
   input  logic [15:0]           req_range_low,
   input  logic [15:0]           req_range_high,
   input  logic [7:0]            req_text_byte,
   input  logic                  q_full,
   output logic                  q_push,
   output u8gim_pkg::entry_type  q_entry
);
   import u8gim_pkg::*;

   logic [1:0]  pending_ff, pending_in;
   logic [15:0] partial_ff, partial_in;
   logic        accept;
   logic        emit;
   logic [15:0] emit_cp;

   assign req_ready = ~q_full;
   assign accept    = req_valid & req_ready;

   always_comb begin
      pending_in = pending_ff;
      partial_in = partial_ff;
      emit       = 1'b0;
      emit_cp    = QMARK;
      if (accept && req_kind) begin
         if (req_text_byte == 8'h00) begin
            // end of text: drop partial sequence
            pending_in = 2'd0;
            partial_in = 16'h0000;
         end else if (pending_ff != 2'd0) begin
            partial_in = {partial_ff[9:0], req_text_byte[5:0]};
            pending_in = pending_ff - 2'd1;
            emit       = (pending_ff == 2'd1);
            emit_cp    = {partial_ff[9:0], req_text_byte[5:0]};
         end else if (req_text_byte[7] == 1'b0) begin
            emit    = 1'b1;
            emit_cp = {8'h00, req_text_byte};
         end else if (req_text_byte[7:5] == 3'b110) begin
            partial_in = {11'h000, req_text_byte[4:0]};
            pending_in = 2'd1;
         end else if (req_text_byte[7:4] == 4'b1110) begin
            partial_in = {12'h000, req_text_byte[3:0]};
            pending_in = 2'd2;
         end else begin
            emit    = 1'b1;
            emit_cp = QMARK;
         end
      end
   end

   always_comb begin
      q_push = accept & (~req_kind | emit);
      if (!req_kind) begin
         q_entry.op   = OP_LOAD;
         q_entry.slot = req_range_slot;
         q_entry.low  = req_range_low;
         q_entry.high = req_range_high;
      end else begin
         q_entry.op   = OP_LOOKUP;
         q_entry.slot = 6'd0;
         q_entry.low  = emit_cp;
         q_entry.high = 16'h0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         partial_ff <= 16'h0000;
      end else begin
         pending_ff <= pending_in;
         partial_ff <= partial_in;
      end
   end

endmodule

### hw/rtl/u8gim_queue.sv
// ----------------------------------------------------------------------------
// u8gim_queue: short entry queue
// Decouples the decoder from the lookup engine.
// ----------------------------------------------------------------------------
module u8gim_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  u8gim_pkg::entry_type  push_entry,
   input  logic                  pop,
   output u8gim_pkg::entry_type  head_entry,
   output logic                  full,
   output logic                  empty
);
   import u8gim_pkg::*;

   entry_type               slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CW-1:0]     count_ff, count_in;

   assign full       = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (full && !pop) |-> !push)
      else $error("queue push while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue pop while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CW'(QUEUE_DEPTH))
      else $error("queue count overflow");

endmodule

### hw/rtl/u8gim_back.sv
// ----------------------------------------------------------------------------
// u8gim_back: range table and glyph lookup engine
// Writes range entries, checks the one-range cache, walks the table.
// ----------------------------------------------------------------------------
module u8gim_back #(
   parameter int MAX_RANGES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  u8gim_pkg::cfg_type    cfg,
   input  logic                  q_empty,
   input  u8gim_pkg::entry_type  q_entry,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [15:0]           rsp_glyph_index,
   output logic [15:0]           rsp_code_point,
   output logic                  rsp_substituted,
   output logic                  rsp_found
);
   import u8gim_pkg::*;

   localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CW = $clog2(MAX_RANGES + 1);

   back_state_type state_ff, state_in;

   logic [31:0]   range_mem [MAX_RANGES];
   logic [31:0]   rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;

   logic          cache_valid_ff, cache_valid_in;
   logic [15:0]   cache_lo_ff, cache_lo_in;
   logic [15:0]   cache_hi_ff, cache_hi_in;
   logic [15:0]   cache_base_ff, cache_base_in;

   logic [15:0]   cp_ff, cp_in;
   logic          sub_ff, sub_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          vld_ff, vld_in;
   logic [15:0]   sum_ff, sum_in;
   logic [15:0]   res_idx_ff, res_idx_in;
   logic          res_found_ff, res_found_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_glyph_index_ff, rsp_glyph_index_in;
   logic [15:0]   rsp_code_point_ff, rsp_code_point_in;
   logic          rsp_substituted_ff, rsp_substituted_in;
   logic          rsp_found_ff, rsp_found_in;

   logic [10:0]   count_wide;
   logic [CW-1:0] n_eff;
   logic [15:0]   slot_wide;
   logic          slot_ok;
   logic [15:0]   key;
   logic [15:0]   rd_lo, rd_hi;
   logic          cache_hit;
   logic          walk_match;
   logic          walk_issue;
   logic          walk_miss;
   logic          retry_qmark;
   logic          out_free;

   // effective range count, clipped to table depth
   assign count_wide = {4'h0, cfg.count};
   assign n_eff      = (count_wide > 11'(MAX_RANGES)) ? CW'(MAX_RANGES) : count_wide[CW-1:0];

   assign slot_wide  = {10'h000, q_entry.slot};
   assign slot_ok    = ({10'h000, q_entry.slot} < 16'(MAX_RANGES));
   assign mem_waddr  = slot_wide[AW-1:0];
   assign mem_raddr  = rd_idx_ff[AW-1:0];

   assign key        = sub_ff ? QMARK : cp_ff;
   assign rd_lo      = rd_data_ff[15:0];
   assign rd_hi      = rd_data_ff[31:16];
   assign cache_hit  = cache_valid_ff && (key >= cache_lo_ff) && (key <= cache_hi_ff);
   assign walk_match = vld_ff && (key >= rd_lo) && (key <= rd_hi);
   assign walk_issue = (rd_idx_ff < n_eff);
   assign walk_miss  = !vld_ff && !walk_issue;
   assign retry_qmark = !sub_ff && (cp_ff != QMARK);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty && q_entry.op == OP_LOOKUP) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = cache_hit ? ST_EMIT : ST_WALK;
         end
         ST_WALK: begin
            if (walk_match) begin
               state_in = ST_EMIT;
            end else if (walk_miss) begin
               state_in = retry_qmark ? ST_LOOK : ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_pop              = 1'b0;
      mem_we             = 1'b0;
      cache_valid_in     = cache_valid_ff;
      cache_lo_in        = cache_lo_ff;
      cache_hi_in        = cache_hi_ff;
      cache_base_in      = cache_base_ff;
      cp_in              = cp_ff;
      sub_in             = sub_ff;
      rd_idx_in          = rd_idx_ff;
      vld_in             = vld_ff;
      sum_in             = sum_ff;
      res_idx_in         = res_idx_ff;
      res_found_in       = res_found_ff;
      rsp_valid_in       = rsp_valid_ff & ~rsp_ready;
      rsp_glyph_index_in = rsp_glyph_index_ff;
      rsp_code_point_in  = rsp_code_point_ff;
      rsp_substituted_in = rsp_substituted_ff;
      rsp_found_in       = rsp_found_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_entry.op == OP_LOAD) begin
                  mem_we         = slot_ok;
                  cache_valid_in = 1'b0;
               end else begin
                  cp_in  = q_entry.low;
                  sub_in = 1'b0;
               end
            end
         end
         ST_LOOK: begin
            rd_idx_in = '0;
            vld_in    = 1'b0;
            sum_in    = 16'h0000;
            if (cache_hit) begin
               res_idx_in   = cache_base_ff + (key - cache_lo_ff);
               res_found_in = 1'b1;
            end
         end
         ST_WALK: begin
            vld_in = walk_issue;
            if (walk_issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (walk_match) begin
               res_idx_in     = sum_ff + (key - rd_lo);
               res_found_in   = 1'b1;
               cache_valid_in = 1'b1;
               cache_lo_in    = rd_lo;
               cache_hi_in    = rd_hi;
               cache_base_in  = sum_ff;
            end else if (vld_ff) begin
               sum_in = sum_ff + (rd_hi - rd_lo) + 16'h0001;
            end else if (walk_miss) begin
               if (retry_qmark) begin
                  sub_in = 1'b1;
               end else begin
                  res_idx_in   = 16'h0000;
                  res_found_in = 1'b0;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_glyph_index_in = res_idx_ff;
               rsp_code_point_in  = cp_ff;
               rsp_substituted_in = sub_ff;
               rsp_found_in       = res_found_ff;
            end
         end
         default: ;
      endcase
      if (cfg.clear) begin
         cache_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cache_valid_ff <= 1'b0;
         vld_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cache_valid_ff <= cache_valid_in;
         vld_ff         <= vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cache_lo_ff        <= cache_lo_in;
      cache_hi_ff        <= cache_hi_in;
      cache_base_ff      <= cache_base_in;
      cp_ff              <= cp_in;
      sub_ff             <= sub_in;
      rd_idx_ff          <= rd_idx_in;
      sum_ff             <= sum_in;
      res_idx_ff         <= res_idx_in;
      res_found_ff       <= res_found_in;
      rsp_glyph_index_ff <= rsp_glyph_index_in;
      rsp_code_point_ff  <= rsp_code_point_in;
      rsp_substituted_ff <= rsp_substituted_in;
      rsp_found_ff       <= rsp_found_in;
   end

   // range table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         range_mem[mem_waddr] <= {q_entry.high, q_entry.low};
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= range_mem[mem_raddr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_glyph_index = rsp_glyph_index_ff;
   assign rsp_code_point  = rsp_code_point_ff;
   assign rsp_substituted = rsp_substituted_ff;
   assign rsp_found       = rsp_found_ff;

   a_load_clears_cache: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && q_pop && q_entry.op == OP_LOAD) |=> !cache_valid_ff)
      else $error("cache survived a range load");
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_glyph_index_ff == 16'h0000))
      else $error("missing glyph with nonzero index");
   a_qmark_not_sub: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_code_point_ff == QMARK) |-> !rsp_substituted_ff)
      else $error("question mark flagged as substituted");
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (rd_idx_ff <= n_eff))
      else $error("walk index past range count");

endmodule

### hw/rtl/utf8_glyph_index_mapper.sv
// ----------------------------------------------------------------------------
// utf8_glyph_index_mapper: UTF-8 decoder with code-range glyph lookup
// Top level: CSR block, decoder front end, entry queue and lookup engine.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries either a range load (req_kind = 0: req_range_slot,
//   req_range_low, req_range_high) or one UTF-8 text byte (req_kind = 1).
//   Loads and finished code points are queued in order for the lookup engine.
//   Every finished code point gives one rsp_ result: glyph index, code point,
//   substitution flag and found flag. A zero byte ends the text, gives no
//   result and drops a partial sequence.
//   Set range_count through the csr_ port while the block is idle; a write
//   also clears the range cache.
// Lookup flow:
//   A lookup that hits the range cache passes ST_IDLE, ST_LOOK and ST_EMIT,
//   which registers the rsp_ result; only then is the next queued item taken.
//   A miss walks the range table one entry per cycle through its single read
//   port, min(range_count, MAX_RANGES) entries per pass; a fallback to '?'
//   adds a second pass. The decoder keeps taking bytes while the queue has room.
// Reset: clears decode state, cache, queue and output register; range table
//   contents stay undefined until loaded.
// Stall: a held rsp_ result blocks the lookup engine, then the queue fills
//   and req_ready drops.
// ----------------------------------------------------------------------------
module utf8_glyph_index_mapper #(
   parameter int MAX_RANGES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_kind,
   input  logic [5:0]                       req_range_slot,
   input  logic [15:0]                      req_range_low,
   input  logic [15:0]                      req_range_high,
   input  logic [7:0]                       req_text_byte,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [15:0]                      rsp_glyph_index,
   output logic [15:0]                      rsp_code_point,
   output logic                             rsp_substituted,
   output logic                             rsp_found,
   // configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [u8gim_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import u8gim_pkg::*;

   logic [6:0] count_ff, count_in;
   logic       csr_wr;
   logic       clear_ff;
   cfg_type    cfg;

   logic       q_push, q_pop, q_full, q_empty;
   entry_type  push_entry, head_entry;

   // register write strobe; reg index is byte address bit 2
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr[2] == REG_RANGE_COUNT);
   assign count_in   = csr_wr ? csr_pwdata[6:0] : count_ff;

   always_comb begin
      csr_prdata = 32'h0000_0000;
      if (csr_paddr[2] == REG_RANGE_COUNT) begin
         csr_prdata = {25'h0000000, count_ff};
      end
   end

   // hold count; pulse a cache clear with each count write
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 7'd0;
         clear_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         clear_ff <= csr_wr;
      end
   end

   assign cfg.count = count_ff;
   assign cfg.clear = clear_ff;

   u8gim_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_range_slot (req_range_slot),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .req_text_byte  (req_text_byte),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (push_entry)
   );

   u8gim_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   u8gim_back #(
      .MAX_RANGES (MAX_RANGES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .q_empty         (q_empty),
      .q_entry         (head_entry),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_glyph_index (rsp_glyph_index),
      .rsp_code_point  (rsp_code_point),
      .rsp_substituted (rsp_substituted),
      .rsp_found       (rsp_found)
   );

endmodule
